### hw/rtl/mdc_pkg.sv
// Shared constants, micro-op format and sequencer program for the cofactor
// determinant unit. No dependencies.
// Used by matrix_determinant_cofactor_unit.
package mdc_pkg;

    localparam int ENTRY_BITS  = 16;
    localparam int MAX_SIZE    = 4;
    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int ADDRW       = $clog2(STORE_DEPTH);
    localparam int SIZEW       = 3;
    localparam int DETW        = 64;

    // 3x3 minors of 16-bit entries stay below 6 * 2^45, so 50 signed bits hold them
    localparam int OPW   = 50;
    localparam int PRODW = OPW + ENTRY_BITS;
    // 4x4 determinant stays below 24 * 2^60
    localparam int ACCW  = 67;

    // six 2x2 minors, then four 3x3 minors indexed by their missing column
    localparam int NPAIRS = 6;
    localparam int MINORS = NPAIRS + MAX_SIZE;
    localparam int MIDXW  = $clog2(MINORS);

    localparam logic [SIZEW-1:0] SIZE_RESET = SIZEW'(4);

    // micro-op kinds
    localparam logic [1:0] K_LDH = 2'd0;   // latch entry into holding register
    localparam logic [1:0] K_MUL = 2'd1;   // multiply entry by operand, accumulate
    localparam logic [1:0] K_END = 2'd2;   // deliver result

    // accumulate modes
    localparam logic [1:0] A_SET = 2'd0;
    localparam logic [1:0] A_ADD = 2'd1;
    localparam logic [1:0] A_SUB = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ADDRW-1:0] addr;
        logic             src_minor;
        logic [MIDXW-1:0] ridx;
        logic [1:0]       amode;
        logic             wr_minor;
        logic [MIDXW-1:0] widx;
    } t_uop;

    // program lengths per size: pairs * 4 + triples * 3 + final terms + end
    localparam int PLEN2    = 5;
    localparam int PLEN3    = 16;
    localparam int PLEN4    = 41;
    localparam int PSTART3  = PLEN2;
    localparam int PSTART4  = PLEN2 + PLEN3;
    localparam int PROG_LEN = PLEN2 + PLEN3 + PLEN4;
    localparam int PCW      = $clog2(PROG_LEN);

    typedef t_uop [PROG_LEN-1:0] t_prog;

    function automatic int pair_idx(int i, int j);
        int k;
        if (i == 0) begin
            k = j - 1;
        end else if (i == 1) begin
            k = j + 1;
        end else begin
            k = 5;
        end
        return k;
    endfunction

    function automatic t_uop mk_op(logic [1:0] kind, int row, int col, int n, logic src,
                                   int ridx, logic [1:0] amode, int widx);
        t_uop u;
        u.kind      = kind;
        u.addr      = ADDRW'(row * n + col);
        u.src_minor = src;
        u.ridx      = MIDXW'(ridx);
        u.amode     = amode;
        u.wr_minor  = (widx >= 0);
        u.widx      = MIDXW'((widx < 0) ? 0 : widx);
        return u;
    endfunction

    // Expansion bottom-up: 2x2 minors of the last two rows, 3x3 minors of the last
    // three rows, then row 0. Term order keeps a minor from being read by the op
    // right after the one that writes it.
    function automatic t_prog build_prog();
        t_prog p;
        int    pc;
        int    r2;
        int    r3;
        int    t;
        int    miss;
        p  = '0;
        pc = 0;
        for (int n = 2; n <= MAX_SIZE; n++) begin
            r2 = n - 2;
            r3 = n - 1;
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    p[pc] = mk_op(K_LDH, r2, i, n, 1'b0, 0, A_SET, -1);
                    pc++;
                    p[pc] = mk_op(K_MUL, r3, j, n, 1'b0, 0, A_SET, -1);
                    pc++;
                    p[pc] = mk_op(K_LDH, r2, j, n, 1'b0, 0, A_SET, -1);
                    pc++;
                    p[pc] = mk_op(K_MUL, r3, i, n, 1'b0, 0, A_SUB, pair_idx(i, j));
                    pc++;
                end
            end
            if (n >= 3) begin
                t = n - 3;
                for (int c0 = 0; c0 < n; c0++) begin
                    for (int c1 = c0 + 1; c1 < n; c1++) begin
                        for (int c2 = c1 + 1; c2 < n; c2++) begin
                            miss = 6 - c0 - c1 - c2;
                            p[pc] = mk_op(K_MUL, t, c2, n, 1'b1, pair_idx(c0, c1),
                                          A_SET, -1);
                            pc++;
                            p[pc] = mk_op(K_MUL, t, c1, n, 1'b1, pair_idx(c0, c2),
                                          A_SUB, -1);
                            pc++;
                            p[pc] = mk_op(K_MUL, t, c0, n, 1'b1, pair_idx(c1, c2),
                                          A_ADD, NPAIRS + miss);
                            pc++;
                        end
                    end
                end
            end
            if (n == 4) begin
                p[pc] = mk_op(K_MUL, 0, 2, n, 1'b1, NPAIRS + 2, A_SET, -1);
                pc++;
                p[pc] = mk_op(K_MUL, 0, 3, n, 1'b1, NPAIRS + 3, A_SUB, -1);
                pc++;
                p[pc] = mk_op(K_MUL, 0, 1, n, 1'b1, NPAIRS + 1, A_SUB, -1);
                pc++;
                p[pc] = mk_op(K_MUL, 0, 0, n, 1'b1, NPAIRS + 0, A_ADD, -1);
                pc++;
            end
            p[pc] = mk_op(K_END, 0, 0, n, 1'b0, 0, A_SET, -1);
            pc++;
        end
        return p;
    endfunction

    localparam t_prog PROG = build_prog();

    function automatic logic [PCW-1:0] prog_start(logic [SIZEW-1:0] n);
        logic [PCW-1:0] s;
        unique case (n)
            SIZEW'(2): s = '0;
            SIZEW'(3): s = PCW'(PSTART3);
            default:   s = PCW'(PSTART4);
        endcase
        return s;
    endfunction

    function automatic logic [ADDRW-1:0] last_index(logic [SIZEW-1:0] n);
        logic [ADDRW-1:0] l;
        unique case (n)
            SIZEW'(2): l = ADDRW'(3);
            SIZEW'(3): l = ADDRW'(8);
            default:   l = ADDRW'(STORE_DEPTH - 1);
        endcase
        return l;
    endfunction

endpackage

### hw/rtl/mdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/matrix_determinant_cofactor_unit.sv
// Exact determinant of an n x n signed matrix (n = 2..4) by cofactor expansion.
// An entry is taken each cycle that start is high and busy is low, row-major, one
// per cycle; after the last entry busy stays high while a small sequencer drives one
// shared 16 x 50 bit multiplier, one product per cycle, fed from the single-read-port
// entry RAM. The result is then on o_det_value / o_overflow for exactly one cycle
// with o_det_valid; the receiver cannot stall it. Results outside signed 64-bit
// range saturate and set o_overflow. A size write (allowed while busy is low)
// restarts the load.
// Depends on mdc_pkg and mdc_ram.
module matrix_determinant_cofactor_unit
    import mdc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ENTRY_BITS-1:0] i_entry_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [SIZEW-1:0]             i_cfg_data,
    output logic                         o_det_valid,
    output logic signed [DETW-1:0]       o_det_value,
    output logic                         o_overflow
);

    logic [SIZEW-1:0] r_size;
    logic [ADDRW-1:0] r_cnt;
    logic             r_busy;
    logic             r_run;
    logic [PCW-1:0]   r_pc;
    logic             r_v2;
    logic             r_v3;
    t_uop             r_op2;
    t_uop             r_op3;

    logic signed [OPW-1:0]   r_h;
    logic signed [OPW-1:0]   r_minor [MINORS];
    logic signed [PRODW-1:0] r_prod;
    logic signed [ACCW-1:0]  r_acc;
    logic signed [DETW-1:0]  r_det;
    logic                    r_ovf;
    logic                    r_dv;

    t_uop                         w_uop;
    logic                         w_load;
    logic                         w_cfg;
    logic [SIZEW-1:0]             w_size_wr;
    logic signed [ENTRY_BITS-1:0] w_rdata;
    logic signed [OPW-1:0]        w_oper;
    logic signed [PRODW-1:0]      w_prod;
    logic signed [ACCW-1:0]       n_acc;
    logic                         w_fits;

    assign w_uop  = PROG[r_pc];
    assign w_load = start & ~r_busy;
    assign w_cfg  = i_cfg_valid & ~r_busy;

    always_comb begin
        if (i_cfg_data < SIZEW'(2)) begin
            w_size_wr = SIZEW'(2);
        end else if (i_cfg_data > SIZEW'(MAX_SIZE)) begin
            w_size_wr = SIZEW'(MAX_SIZE);
        end else begin
            w_size_wr = i_cfg_data;
        end
    end

    mdc_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(r_cnt),
        .i_wdata(i_entry_value),
        .i_raddr(w_uop.addr),
        .o_rdata(w_rdata)
    );

    // sequencer: issue (RAM read), multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_run  <= 1'b0;
            r_pc   <= '0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_dv   <= 1'b0;
        end else begin
            if (w_cfg) begin
                r_size <= w_size_wr;
                r_cnt  <= '0;
            end else if (w_load) begin
                if (r_cnt == last_index(r_size)) begin
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                    r_run  <= 1'b1;
                    r_pc   <= prog_start(r_size);
                end else begin
                    r_cnt <= r_cnt + ADDRW'(1);
                end
            end
            if (r_run) begin
                r_pc <= r_pc + PCW'(1);
                if (w_uop.kind == K_END) begin
                    r_run <= 1'b0;
                end
            end
            r_v2 <= r_run;
            r_v3 <= r_v2;
            r_dv <= r_v3 && (r_op3.kind == K_END);
            if (r_v3 && r_op3.kind == K_END) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign w_oper = r_op2.src_minor ? r_minor[r_op2.ridx] : r_h;
    assign w_prod = w_rdata * w_oper;

    always_comb begin
        unique case (r_op3.amode)
            A_SET:   n_acc = ACCW'(r_prod);
            A_ADD:   n_acc = r_acc + ACCW'(r_prod);
            A_SUB:   n_acc = r_acc - ACCW'(r_prod);
            default: n_acc = r_acc;
        endcase
    end

    // fits in 64 bits when the top bits are a pure sign extension
    assign w_fits = (&r_acc[ACCW-1:DETW-1]) | ~(|r_acc[ACCW-1:DETW-1]);

    always_ff @(posedge i_clk) begin
        r_op2 <= w_uop;
        r_op3 <= r_op2;
        if (r_v2 && r_op2.kind == K_LDH) begin
            r_h <= OPW'(w_rdata);
        end
        if (r_v2 && r_op2.kind == K_MUL) begin
            r_prod <= w_prod;
        end
        if (r_v3 && r_op3.kind == K_MUL) begin
            r_acc <= n_acc;
            if (r_op3.wr_minor) begin
                r_minor[r_op3.widx] <= n_acc[OPW-1:0];
            end
        end
        if (r_v3 && r_op3.kind == K_END) begin
            r_ovf <= ~w_fits;
            if (w_fits) begin
                r_det <= r_acc[DETW-1:0];
            end else if (r_acc[ACCW-1]) begin
                r_det <= {1'b1, {(DETW-1){1'b0}}};
            end else begin
                r_det <= {1'b0, {(DETW-1){1'b1}}};
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign o_det_valid = r_dv;
    assign o_det_value = r_det;
    assign o_overflow  = r_ovf;

endmodule

### sim/testbench.sv
// Self-checking bench for matrix_determinant_cofactor_unit: loads corner and random
// matrices of every size, predicts each determinant exactly and checks results in order.
// Depends on mdc_pkg and the unit's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mdc_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [DETW-1:0] value;
        logic                   ovf;
    } t_det_result;

    localparam logic signed [ENTRY_BITS-1:0] ENTRY_MIN = {1'b1, {(ENTRY_BITS-1){1'b0}}};
    localparam logic signed [ENTRY_BITS-1:0] ENTRY_MAX = ~ENTRY_MIN;
    // 4x4 Sylvester Hadamard sign pattern, bit set where the entry is -1
    localparam logic [15:0] HADAMARD_NEG = 16'b0110_1100_1010_0000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [ENTRY_BITS-1:0] i_entry_value = '0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [SIZEW-1:0]             i_cfg_data = '0;
    logic                         o_det_valid;
    logic signed [DETW-1:0]       o_det_value;
    logic                         o_overflow;

    // predictor state
    logic signed [ENTRY_BITS-1:0] entry_store [STORE_DEPTH];
    int unsigned                  fill_count = 0;
    int unsigned                  side = 4;
    t_det_result                  pending_dets [$];
    int                           mismatch_count = 0;
    bit                           steady = 1'b0;

    matrix_determinant_cofactor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_entry_value (i_entry_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_det_valid   (o_det_valid),
        .o_det_value   (o_det_value),
        .o_overflow    (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("matrix_determinant_cofactor_unit: mismatch");
        $finish;
    end

    function automatic t_wide entry_at(int r, int c);
        t_wide w;
        w = t_wide'(entry_store[r * side + c]);
        return w;
    endfunction

    function automatic t_wide det2(int r, int ca, int cb);
        return entry_at(r, ca) * entry_at(r + 1, cb) - entry_at(r, cb) * entry_at(r + 1, ca);
    endfunction

    function automatic t_wide det3(int r, int c0, int c1, int c2);
        return entry_at(r, c0) * det2(r + 1, c1, c2)
             - entry_at(r, c1) * det2(r + 1, c0, c2)
             + entry_at(r, c2) * det2(r + 1, c0, c1);
    endfunction

    function automatic t_wide matrix_det();
        t_wide d;
        case (side)
            2: begin
                d = det2(0, 0, 1);
            end
            3: begin
                d = det3(0, 0, 1, 2);
            end
            default: begin
                d = entry_at(0, 0) * det3(1, 1, 2, 3) - entry_at(0, 1) * det3(1, 0, 2, 3)
                  + entry_at(0, 2) * det3(1, 0, 1, 3) - entry_at(0, 3) * det3(1, 0, 1, 2);
            end
        endcase
        return d;
    endfunction

    function automatic t_det_result saturate(t_wide d);
        t_det_result r;
        r.ovf = !((&d[127:63]) || !(|d[127:63]));
        if (!r.ovf) begin
            r.value = d[63:0];
        end else if (d[127]) begin
            r.value = {1'b1, {63{1'b0}}};
        end else begin
            r.value = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    function automatic void take_entry(logic signed [ENTRY_BITS-1:0] v);
        entry_store[fill_count] = v;
        fill_count++;
        if (fill_count == side * side) begin
            fill_count = 0;
            pending_dets.insert(pending_dets.size(), saturate(matrix_det()));
        end
    endfunction

    function automatic void set_side(logic [SIZEW-1:0] sz);
        if (sz < 2) begin
            side = 2;
        end else if (sz > MAX_SIZE) begin
            side = MAX_SIZE;
        end else begin
            side = 32'(sz);
        end
        fill_count = 0;
    endfunction

    function automatic logic signed [ENTRY_BITS-1:0] random_entry(bit extreme_only);
        logic signed [ENTRY_BITS-1:0] v;
        int                           s;
        if (extreme_only) begin
            v = $urandom_range(0, 1) ? ENTRY_MIN : ENTRY_MAX;
        end else begin
            case ($urandom_range(0, 9))
                6, 7: begin
                    case ($urandom_range(0, 4))
                        0: v = ENTRY_MIN;
                        1: v = ENTRY_MAX;
                        2: v = '0;
                        3: v = 1;
                        default: v = '1;
                    endcase
                end
                8, 9: begin
                    s = int'($urandom_range(0, 16)) - 8;
                    v = s[ENTRY_BITS-1:0];
                end
                default: begin
                    v = ENTRY_BITS'($urandom);
                end
            endcase
        end
        return v;
    endfunction

    // Called at a clock edge; returns at the edge that accepts the request with
    // start still high so back-to-back requests need no extra step.
    task automatic send_entry(input logic signed [ENTRY_BITS-1:0] v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_entry_value <= v;
        do @(posedge i_clk); while (busy);
        take_entry(v);
    endtask

    // Sender stops until every pending determinant is out, then lets the unit go quiet.
    task automatic settle();
        start <= 1'b0;
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZEW-1:0] sz);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        set_side(sz);
    endtask

    task automatic send_matrix(input bit extreme_only);
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < side * side; i++) begin
            send_entry(random_entry(extreme_only));
        end
    endtask

    // swap exchanges rows 0 and 1, flipping the sign of the determinant
    task automatic send_hadamard(input bit swap);
        int src;
        for (int r = 0; r < 4; r++) begin
            src = (swap && r < 2) ? 1 - r : r;
            for (int c = 0; c < 4; c++) begin
                send_entry(HADAMARD_NEG[src * 4 + c] ? ENTRY_MAX : ENTRY_MIN);
            end
        end
    endtask

    // reset size is 4; this determinant is near +2^64 and must saturate
    task automatic test_hadamard_overflow();
        send_hadamard(1'b0);
    endtask

    // size 0 clamps to 2
    task automatic test_size_two_corners();
        write_size(3'd0);
        send_entry(ENTRY_MIN);
        send_entry(ENTRY_MAX);
        send_entry(ENTRY_MIN);
        send_entry(ENTRY_MIN);
    endtask

    // a size write drops a partial load; sizes above the max clamp to 4, below 2 to 2
    task automatic test_midload_restart();
        write_size(3'd3);
        send_entry(16'sd5);
        send_entry(-16'sd7);
        send_entry(16'sd9);
        write_size(3'd7);
        write_size(3'd1);
        send_entry(16'sd1);
        send_entry(16'sd2);
        send_entry(16'sd3);
        send_entry(16'sd4);
    endtask

    task automatic test_random_loads();
        logic [SIZEW-1:0] codes [10];
        int               sent;
        int               partial;
        codes = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd1, 3'd0, 3'd3, 3'd4};
        foreach (codes[k]) begin
            write_size(codes[k]);
            sent = 0;
            while (sent < 88) begin
                send_matrix(1'b0);
                sent += side * side;
            end
            // trailing partial matrix, discarded by the next size write
            steady = 1'b0;
            partial = $urandom_range(0, side * side - 1);
            for (int i = 0; i < partial; i++) begin
                send_entry(random_entry(1'b0));
            end
        end
    endtask

    task automatic test_saturation();
        write_size(3'd4);
        steady = 1'b0;
        send_hadamard(1'b1);
        for (int k = 0; k < 5; k++) begin
            send_matrix(1'b1);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_det_result want;
        if (i_rst_n && o_det_valid) begin
            if (pending_dets.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: det=%0d ovf=%0b", o_det_value, o_overflow);
                end
            end else begin
                want = pending_dets.pop_front();
                if (o_det_value !== want.value || o_overflow !== want.ovf) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("det: expected %0d ovf %0b, got %0d ovf %0b",
                                 want.value, want.ovf, o_det_value, o_overflow);
                    end
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hadamard_overflow();
        test_size_two_corners();
        test_midload_restart();
        test_random_loads();
        test_saturation();
        settle();
        if (mismatch_count == 0 && pending_dets.size() == 0) begin
            $display("matrix_determinant_cofactor_unit: match");
        end else begin
            $display("matrix_determinant_cofactor_unit: mismatch");
        end
        $finish;
    end

endmodule
